// ===== design/stq_pkg.sv =====
package stq_pkg;

    // request codes
    localparam logic [2:0] REQ_CHECK     = 3'd0;
    localparam logic [2:0] REQ_ADD       = 3'd1;
    localparam logic [2:0] REQ_DELETE    = 3'd2;
    localparam logic [2:0] REQ_CLEAR     = 3'd3;
    localparam logic [2:0] REQ_CLEAR_EXC = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_EXPIRED   = 3'd0;
    localparam logic [2:0] KIND_ADDED     = 3'd1;
    localparam logic [2:0] KIND_FULL      = 3'd2;
    localparam logic [2:0] KIND_DELETED   = 3'd3;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd4;
    localparam logic [2:0] KIND_CLEARED   = 3'd5;
    localparam logic [2:0] KIND_NONE      = 3'd6;

    localparam int RESULT_LIMIT = 16;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  handler;
        logic [15:0] context_tag;
        logic [31:0] start;
        logic [30:0] duration;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK_RD,
        ST_CHECK_EV,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_ADD_RD,
        ST_ADD_EV,
        ST_INS_RD,
        ST_INS_WR,
        ST_DEL_RD,
        ST_DEL_EV,
        ST_EXC_RD,
        ST_EXC_EV,
        ST_OUT
    } state_t;

endpackage

// ===== design/stq_mem.sv =====
module stq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  stq_pkg::entry_t    wr_data,
    input  logic [AW-1:0]      rd_addr,
    output stq_pkg::entry_t    rd_data
);

    stq_pkg::entry_t mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/sorted_timer_queue.sv =====
// Ordered timer queue held in one single-port-write, registered-read memory.
// One request is taken at a time; s_axis_tready is low until its last result
// has been handed over. All work goes through one shared read/compare/write
// path under a sequencer. A check reads the head; each popped entry is held
// while the queue shifts down and the next head is read, so that its last
// flag is known before it leaves. A check pops at most RESULT_LIMIT entries.
// An add walks the queue and opens a gap, a delete walks and shifts, a
// clear-except walks and compacts, and a clear all resets the count. Output
// stalls can hold any request. Results leave through a single output
// register; unknown request codes give none.
module sorted_timer_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type[2:0], now_ms[34:3], timer_tag[50:35], timeout_ms[81:51],
    // handler_tag[89:82], context_tag[105:90], zero [111:106]
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // kind[2:0], out_timer_tag[18:3], out_handler_tag[26:19],
    // out_context_tag[42:27], zero [47:43]
    output logic [47:0]  m_axis_tdata,
    output logic         m_axis_tlast
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int NW = $clog2(stq_pkg::RESULT_LIMIT + 1);

    stq_pkg::state_t state_reg, state_next;

    logic [2:0]    req_reg;
    logic [31:0]   now_reg;
    logic [15:0]   tag_reg;
    logic [30:0]   tmo_reg;
    logic [7:0]    hnd_reg;
    logic [15:0]   ctx_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;    // read pointer
    logic [CW-1:0] dst_reg, dst_next;    // write pointer / insert slot
    logic [NW-1:0] pops_reg, pops_next;
    logic          found_reg, found_next;
    logic          pend_reg, pend_next;  // popped item held in the output regs

    logic [2:0]    o_kind_reg, o_kind_next;
    logic [15:0]   o_tag_reg, o_tag_next;
    logic [7:0]    o_hnd_reg, o_hnd_next;
    logic [15:0]   o_ctx_reg, o_ctx_next;
    logic          o_last_reg, o_last_next;
    logic          o_valid_reg, o_valid_next;
    stq_pkg::state_t o_ret_reg, o_ret_next;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    stq_pkg::entry_t wr_data;
    logic [AW-1:0]   rd_addr;
    stq_pkg::entry_t rd_data;
    stq_pkg::entry_t new_entry;

    // pending move of the gap walk
    logic          insert_move_reg;
    logic [AW-1:0] move_dst_reg;

    logic          in_acc;
    logic          out_acc;
    logic [31:0]   elapsed;
    logic [31:0]   remain;
    logic          expired;
    logic          alive;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    stq_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared time unit on the entry just read
    assign elapsed = now_reg - rd_data.start;
    assign expired = elapsed >= {1'b0, rd_data.duration};
    assign remain  = rd_data.start + {1'b0, rd_data.duration} - now_reg;
    assign alive   = (remain != 32'd0) && !remain[31];

    assign new_entry.id          = tag_reg;
    assign new_entry.handler     = hnd_reg;
    assign new_entry.context_tag = ctx_reg;
    assign new_entry.start       = now_reg;
    assign new_entry.duration    = tmo_reg;

    // request capture and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= stq_pkg::ST_IDLE;
            count_reg   <= '0;
            o_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            o_valid_reg <= o_valid_next;
        end
        if (in_acc) begin
            req_reg <= s_axis_tdata[2:0];
            now_reg <= s_axis_tdata[34:3];
            tag_reg <= s_axis_tdata[50:35];
            tmo_reg <= s_axis_tdata[81:51];
            hnd_reg <= s_axis_tdata[89:82];
            ctx_reg <= s_axis_tdata[105:90];
        end
        idx_reg    <= idx_next;
        dst_reg    <= dst_next;
        pops_reg   <= pops_next;
        found_reg  <= found_next;
        pend_reg   <= pend_next;
        o_kind_reg <= o_kind_next;
        o_tag_reg  <= o_tag_next;
        o_hnd_reg  <= o_hnd_next;
        o_ctx_reg  <= o_ctx_next;
        o_last_reg <= o_last_next;
        o_ret_reg  <= o_ret_next;
    end

    // sequencer: next state and datapath updates
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        dst_next     = dst_reg;
        pops_next    = pops_reg;
        found_next   = found_reg;
        pend_next    = pend_reg;
        o_kind_next  = o_kind_reg;
        o_tag_next   = o_tag_reg;
        o_hnd_next   = o_hnd_reg;
        o_ctx_next   = o_ctx_reg;
        o_last_next  = o_last_reg;
        o_valid_next = o_valid_reg;
        o_ret_next   = o_ret_reg;
        unique case (state_reg)
            stq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    idx_next   = '0;
                    dst_next   = '0;
                    pops_next  = '0;
                    found_next = 1'b0;
                    pend_next  = 1'b0;
                    o_tag_next = '0;
                    o_hnd_next = '0;
                    o_ctx_next = '0;
                    o_last_next = 1'b1;
                    o_ret_next = stq_pkg::ST_IDLE;
                    case (s_axis_tdata[2:0])
                        stq_pkg::REQ_CHECK: begin
                            if (count_reg == '0) begin
                                o_kind_next  = stq_pkg::KIND_NONE;
                                o_valid_next = 1'b1;
                                state_next   = stq_pkg::ST_OUT;
                            end else begin
                                state_next = stq_pkg::ST_CHECK_RD;
                            end
                        end
                        stq_pkg::REQ_ADD: begin
                            o_tag_next = s_axis_tdata[50:35];
                            if (count_reg >= CW'(QUEUE_DEPTH)) begin
                                o_kind_next  = stq_pkg::KIND_FULL;
                                o_valid_next = 1'b1;
                                state_next   = stq_pkg::ST_OUT;
                            end else begin
                                dst_next   = count_reg;
                                state_next = (count_reg == '0) ? stq_pkg::ST_INS_WR
                                                               : stq_pkg::ST_ADD_RD;
                            end
                        end
                        stq_pkg::REQ_DELETE: begin
                            o_tag_next = s_axis_tdata[50:35];
                            if (count_reg == '0) begin
                                o_kind_next  = stq_pkg::KIND_NOT_FOUND;
                                o_valid_next = 1'b1;
                                state_next   = stq_pkg::ST_OUT;
                            end else begin
                                state_next = stq_pkg::ST_DEL_RD;
                            end
                        end
                        stq_pkg::REQ_CLEAR: begin
                            count_next   = '0;
                            o_kind_next  = stq_pkg::KIND_CLEARED;
                            o_valid_next = 1'b1;
                            state_next   = stq_pkg::ST_OUT;
                        end
                        stq_pkg::REQ_CLEAR_EXC: begin
                            if (count_reg == '0) begin
                                o_kind_next  = stq_pkg::KIND_CLEARED;
                                o_valid_next = 1'b1;
                                state_next   = stq_pkg::ST_OUT;
                            end else begin
                                state_next = stq_pkg::ST_EXC_RD;
                            end
                        end
                        default: begin
                            state_next = stq_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            // check: read head, pop if expired
            stq_pkg::ST_CHECK_RD: begin
                state_next = stq_pkg::ST_CHECK_EV;
            end
            stq_pkg::ST_CHECK_EV: begin
                if (pend_reg) begin
                    // held item leaves once the new head is known
                    o_valid_next = 1'b1;
                    o_last_next  = !expired;
                    o_ret_next   = expired ? stq_pkg::ST_CHECK_RD : stq_pkg::ST_IDLE;
                    pend_next    = 1'b0;
                    state_next   = stq_pkg::ST_OUT;
                end else if (expired) begin
                    o_kind_next  = stq_pkg::KIND_EXPIRED;
                    o_tag_next   = rd_data.id;
                    o_hnd_next   = rd_data.handler;
                    o_ctx_next   = rd_data.context_tag;
                    pend_next    = 1'b1;
                    pops_next    = pops_reg + NW'(1);
                    count_next   = count_reg - CW'(1);
                    idx_next     = CW'(1);
                    dst_next     = '0;
                    state_next   = stq_pkg::ST_SHIFT_RD;
                end else begin
                    o_kind_next  = stq_pkg::KIND_NONE;
                    o_valid_next = 1'b1;
                    o_last_next  = 1'b1;
                    o_ret_next   = stq_pkg::ST_IDLE;
                    state_next   = stq_pkg::ST_OUT;
                end
            end
            // shift entries down by one after a head pop or a delete
            stq_pkg::ST_SHIFT_RD: begin
                if (idx_reg > count_reg) begin
                    idx_next = '0;
                    if (!found_reg && count_reg != '0 &&
                        pops_reg != NW'(stq_pkg::RESULT_LIMIT)) begin
                        state_next = stq_pkg::ST_CHECK_RD;
                    end else begin
                        // final item of a check, or the delete result
                        o_valid_next = 1'b1;
                        o_last_next  = 1'b1;
                        o_ret_next   = stq_pkg::ST_IDLE;
                        pend_next    = 1'b0;
                        state_next   = stq_pkg::ST_OUT;
                    end
                end else begin
                    state_next = stq_pkg::ST_SHIFT_WR;
                end
            end
            stq_pkg::ST_SHIFT_WR: begin
                idx_next   = idx_reg + CW'(1);
                dst_next   = dst_reg + CW'(1);
                state_next = stq_pkg::ST_SHIFT_RD;
            end
            // add: find the insert slot
            stq_pkg::ST_ADD_RD: begin
                state_next = stq_pkg::ST_ADD_EV;
            end
            stq_pkg::ST_ADD_EV: begin
                if (alive && ({1'b0, tmo_reg} < remain)) begin
                    dst_next   = idx_reg;
                    idx_next   = count_reg;
                    state_next = stq_pkg::ST_INS_RD;
                end else if (idx_reg + CW'(1) == count_reg) begin
                    state_next = stq_pkg::ST_INS_WR;
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = stq_pkg::ST_ADD_RD;
                end
            end
            // open a gap from the tail down to the insert slot
            stq_pkg::ST_INS_RD: begin
                if (idx_reg == dst_reg) begin
                    state_next = stq_pkg::ST_INS_WR;
                end else begin
                    idx_next   = idx_reg - CW'(1);
                    state_next = stq_pkg::ST_INS_RD;
                end
            end
            stq_pkg::ST_INS_WR: begin
                count_next   = count_reg + CW'(1);
                o_kind_next  = stq_pkg::KIND_ADDED;
                o_valid_next = 1'b1;
                state_next   = stq_pkg::ST_OUT;
            end
            // delete: search, then reuse the shift path
            stq_pkg::ST_DEL_RD: begin
                state_next = stq_pkg::ST_DEL_EV;
            end
            stq_pkg::ST_DEL_EV: begin
                if (rd_data.id == tag_reg) begin
                    count_next  = count_reg - CW'(1);
                    dst_next    = idx_reg;
                    idx_next    = idx_reg + CW'(1);
                    found_next  = 1'b1;
                    state_next  = stq_pkg::ST_SHIFT_RD;
                    o_kind_next = stq_pkg::KIND_DELETED;
                    pops_next   = NW'(stq_pkg::RESULT_LIMIT);
                end else if (idx_reg + CW'(1) == count_reg) begin
                    o_kind_next  = stq_pkg::KIND_NOT_FOUND;
                    o_valid_next = 1'b1;
                    state_next   = stq_pkg::ST_OUT;
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = stq_pkg::ST_DEL_RD;
                end
            end
            // clear except: compact kept entries
            stq_pkg::ST_EXC_RD: begin
                state_next = stq_pkg::ST_EXC_EV;
            end
            stq_pkg::ST_EXC_EV: begin
                if (rd_data.handler == hnd_reg) begin
                    dst_next = dst_reg + CW'(1);
                end
                if (idx_reg + CW'(1) == count_reg) begin
                    count_next   = (rd_data.handler == hnd_reg) ? dst_reg + CW'(1)
                                                                 : dst_reg;
                    o_kind_next  = stq_pkg::KIND_CLEARED;
                    o_valid_next = 1'b1;
                    state_next   = stq_pkg::ST_OUT;
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = stq_pkg::ST_EXC_RD;
                end
            end
            stq_pkg::ST_OUT: begin
                if (out_acc) begin
                    o_valid_next = 1'b0;
                    state_next   = o_ret_reg;
                end
            end
            default: begin
                state_next = stq_pkg::ST_IDLE;
            end
        endcase
    end

    // memory port control
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = dst_reg[AW-1:0];
        wr_data = rd_data;
        rd_addr = idx_reg[AW-1:0];
        unique case (state_reg)
            stq_pkg::ST_SHIFT_WR: begin
                wr_en = 1'b1;
            end
            stq_pkg::ST_INS_RD: begin
                // read slot idx-1 now, write it to slot idx next cycle
                rd_addr = idx_reg[AW-1:0] - AW'(1);
                wr_en   = 1'b0;
            end
            stq_pkg::ST_INS_WR: begin
                wr_en   = 1'b1;
                wr_data = new_entry;
            end
            stq_pkg::ST_EXC_EV: begin
                wr_en = (rd_data.handler == hnd_reg);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
        // gap move: rd_data holds slot idx from the previous cycle
        if (state_reg == stq_pkg::ST_INS_RD && insert_move_reg) begin
            wr_en   = 1'b1;
            wr_addr = move_dst_reg;
        end
    end

    // pending move of the gap walk
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            insert_move_reg <= 1'b0;
        end else begin
            insert_move_reg <= (state_reg == stq_pkg::ST_INS_RD) && (idx_reg != dst_reg);
        end
        move_dst_reg <= idx_reg[AW-1:0];
    end

    assign s_axis_tready = (state_reg == stq_pkg::ST_IDLE);
    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {5'd0, o_ctx_reg, o_hnd_reg, o_tag_reg, o_kind_reg};
    assign m_axis_tlast  = o_last_reg;

    // results only leave from the output state
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> state_reg == stq_pkg::ST_OUT)
        else $error("result valid outside output state");

    // queue never grows beyond its depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count overflow");

    // a new request is never taken while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request accepted with result pending");

endmodule
